>>> sv/hcb_pkg.sv
`default_nettype none
package hcb_pkg;

    localparam int ALPHABET    = 256;
    localparam int COUNT_BITS  = 32;
    localparam int SYM_BITS    = $clog2(ALPHABET);
    localparam int NODE_MAX    = 2 * ALPHABET - 1;
    localparam int NODE_BITS   = $clog2(NODE_MAX + 1);
    localparam int WEIGHT_BITS = COUNT_BITS + SYM_BITS;
    localparam int CODE_BITS   = 64;
    localparam int LEN_BITS    = 8;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_BUILD = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_LONG    = 2'd1;
    localparam logic [1:0] STAT_NO_TREE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QUERY,
        ST_LEAF,
        ST_SCAN,
        ST_MRG_A,
        ST_MRG_B,
        ST_MRG_N,
        ST_ROOT,
        ST_WALK_RD,
        ST_WALK_L,
        ST_WALK_R,
        ST_ASSIGN
    } state_t;

    typedef struct packed {
        logic [NODE_BITS-1:0]   i1;
        logic [NODE_BITS-1:0]   i2;
        logic [WEIGHT_BITS-1:0] w1;
        logic [WEIGHT_BITS-1:0] w2;
    } pick_t;

endpackage
`default_nettype wire

>>> sv/hcb_pick2.sv
`default_nettype none
module hcb_pick2 (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               clr,
    input  wire logic                               en,
    input  wire logic                               active,
    input  wire logic [hcb_pkg::NODE_BITS-1:0]      idx,
    input  wire logic [hcb_pkg::WEIGHT_BITS-1:0]    weight,
    output hcb_pkg::pick_t                          pick
);

    logic f1_reg;
    logic f2_reg;
    hcb_pkg::pick_t p_reg;

    // lightest two, ascending index scan, strict compare keeps the lower index on ties
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_reg <= 1'b0;
            f2_reg <= 1'b0;
        end
        else if (clr)
        begin
            f1_reg <= 1'b0;
            f2_reg <= 1'b0;
        end
        else if (en && active)
        begin
            if (!f1_reg || weight < p_reg.w1)
            begin
                f1_reg <= 1'b1;
                f2_reg <= f1_reg;
            end
            else if (!f2_reg || weight < p_reg.w2)
            begin
                f2_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!clr && en && active)
        begin
            if (!f1_reg || weight < p_reg.w1)
            begin
                p_reg.i2 <= p_reg.i1;
                p_reg.w2 <= p_reg.w1;
                p_reg.i1 <= idx;
                p_reg.w1 <= weight;
            end
            else if (!f2_reg || weight < p_reg.w2)
            begin
                p_reg.i2 <= idx;
                p_reg.w2 <= weight;
            end
        end
    end

    assign pick = p_reg;

endmodule
`default_nettype wire

>>> sv/huffman_code_builder_core.sv
`default_nettype none
// write and unused items: result registered in the cycle after accept
// query: the table read is registered, then the result; build: a leaf pass, one
//   lightest-pair scan over the node store per merge, a walk and a table pass
// one item at a time; input stalls until the result is taken
// reset clears counts, code table, tree flag and output valid
module huffman_code_builder_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [1:0]                        req_type,
    input  wire logic [7:0]                        symbol,
    input  wire logic [31:0]                       count,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [63:0]                            code_bits,
    output logic [7:0]                             code_length,
    output logic [1:0]                             status
);

    localparam int NB = hcb_pkg::NODE_BITS;
    localparam int SB = hcb_pkg::SYM_BITS;
    localparam int WB = hcb_pkg::WEIGHT_BITS;
    localparam int CB = hcb_pkg::CODE_BITS;
    localparam int LB = hcb_pkg::LEN_BITS;
    localparam int AL = hcb_pkg::ALPHABET;
    localparam int NM = hcb_pkg::NODE_MAX;

    hcb_pkg::state_t state_reg, state_next;
    logic [NB-1:0] idx_reg, idx_next;
    logic          pend_reg, pend_next;
    logic [NB-1:0] rd_idx_reg;
    logic [NB-1:0] leaves_reg, leaves_next;
    logic [NB-1:0] total_reg, total_next;
    logic [NB-1:0] live_reg, live_next;
    logic          tree_reg, tree_next;

    logic          out_valid_reg;
    logic [CB-1:0] out_code_reg;
    logic [LB-1:0] out_len_reg;
    logic [1:0]    out_stat_reg;
    logic          out_load;
    logic [CB-1:0] out_code;
    logic [LB-1:0] out_len;
    logic [1:0]    out_stat;

    logic accept;

    // count store
    logic [hcb_pkg::COUNT_BITS-1:0] cnt_mem [AL];
    logic [AL-1:0]                  cnt_vld_reg;
    logic [hcb_pkg::COUNT_BITS-1:0] cnt_rd_reg;
    logic                           cnt_vld_rd_reg;
    logic                           cnt_we;

    // node store: active flag and weight
    logic [WB:0]   w_mem [NM];
    logic [WB:0]   w_rd_reg;
    logic          w_we;
    logic [NB-1:0] w_waddr;
    logic [WB:0]   w_wdata;

    logic [2*NB-1:0] ch_mem [NM];
    logic [2*NB-1:0] ch_rd_reg;
    logic            ch_we;

    logic [SB-1:0] ls_mem [AL];
    logic [SB-1:0] ls_rd_reg;
    logic          ls_we;

    logic [CB+LB-1:0] wk_mem [NM];
    logic [CB+LB-1:0] wk_rd_reg;
    logic             wk_we;
    logic [NB-1:0]    wk_waddr;
    logic [CB+LB-1:0] wk_wdata;

    // per-symbol code table
    logic [CB+LB-1:0] tab_mem [AL];
    logic [AL-1:0]    tab_vld_reg;
    logic [CB+LB-1:0] tab_rd_reg;
    logic             tab_vld_rd_reg;
    logic             tab_we;
    logic             tab_clr;
    logic [CB+LB-1:0] tab_wdata;
    logic             q_rd;

    logic           pick_clr;
    logic           pick_en;
    hcb_pkg::pick_t pick;

    logic [CB-1:0] wk_code;
    logic [LB-1:0] wk_len;
    logic [LB-1:0] tab_len;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != hcb_pkg::ST_IDLE) || out_valid_reg;
    assign wk_code  = wk_rd_reg[CB+LB-1:LB];
    assign wk_len   = wk_rd_reg[LB-1:0];
    assign tab_len  = tab_rd_reg[LB-1:0];

    hcb_pick2 u_pick (
        .clk    (clk),
        .rst_n  (rst_n),
        .clr    (pick_clr),
        .en     (pick_en),
        .active (w_rd_reg[WB]),
        .idx    (rd_idx_reg),
        .weight (w_rd_reg[WB-1:0]),
        .pick   (pick)
    );

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[symbol[SB-1:0]] <= count[hcb_pkg::COUNT_BITS-1:0];
        end
        cnt_rd_reg     <= cnt_mem[idx_reg[SB-1:0]];
        cnt_vld_rd_reg <= cnt_vld_reg[idx_reg[SB-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_vld_reg <= '0;
        end
        else if (cnt_we)
        begin
            cnt_vld_reg[symbol[SB-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            w_mem[w_waddr] <= w_wdata;
        end
        w_rd_reg <= w_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ch_we)
        begin
            ch_mem[total_reg] <= {pick.i1, pick.i2};
        end
        ch_rd_reg <= ch_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ls_we)
        begin
            ls_mem[leaves_reg[SB-1:0]] <= rd_idx_reg[SB-1:0];
        end
        ls_rd_reg <= ls_mem[idx_reg[SB-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (wk_we)
        begin
            wk_mem[wk_waddr] <= wk_wdata;
        end
        wk_rd_reg <= wk_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_mem[ls_rd_reg] <= tab_wdata;
        end
        if (q_rd)
        begin
            tab_rd_reg     <= tab_mem[symbol[SB-1:0]];
            tab_vld_rd_reg <= tab_vld_reg[symbol[SB-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tab_vld_reg <= '0;
        end
        else if (tab_clr)
        begin
            tab_vld_reg <= '0;
        end
        else if (tab_we)
        begin
            tab_vld_reg[ls_rd_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hcb_pkg::ST_IDLE;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            rd_idx_reg    <= '0;
            leaves_reg    <= '0;
            total_reg     <= '0;
            live_reg      <= '0;
            tree_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            pend_reg   <= pend_next;
            rd_idx_reg <= idx_reg;
            leaves_reg <= leaves_next;
            total_reg  <= total_next;
            live_reg   <= live_next;
            tree_reg   <= tree_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_code_reg <= out_code;
            out_len_reg  <= out_len;
            out_stat_reg <= out_stat;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        pend_next   = 1'b0;
        leaves_next = leaves_reg;
        total_next  = total_reg;
        live_next   = live_reg;
        tree_next   = tree_reg;
        out_load    = 1'b0;
        out_code    = '0;
        out_len     = '0;
        out_stat    = hcb_pkg::STAT_OK;
        cnt_we      = 1'b0;
        w_we        = 1'b0;
        w_waddr     = leaves_reg;
        w_wdata     = {1'b1, {SB{1'b0}}, cnt_rd_reg};
        ch_we       = 1'b0;
        ls_we       = 1'b0;
        wk_we       = 1'b0;
        wk_waddr    = total_reg - 1'b1;
        wk_wdata    = '0;
        tab_we      = 1'b0;
        tab_clr     = 1'b0;
        tab_wdata   = wk_rd_reg;
        q_rd        = 1'b0;
        pick_clr    = 1'b0;
        pick_en     = 1'b0;

        unique case (state_reg)
            hcb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        hcb_pkg::REQ_WRITE:
                        begin
                            cnt_we   = ({1'b0, symbol} < (SB+1)'(AL));
                            out_load = 1'b1;
                        end
                        hcb_pkg::REQ_BUILD:
                        begin
                            tab_clr     = 1'b1;
                            idx_next    = '0;
                            leaves_next = '0;
                            state_next  = hcb_pkg::ST_LEAF;
                        end
                        hcb_pkg::REQ_QUERY:
                        begin
                            q_rd       = 1'b1;
                            state_next = hcb_pkg::ST_QUERY;
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            hcb_pkg::ST_QUERY:
            begin
                out_load   = 1'b1;
                state_next = hcb_pkg::ST_IDLE;
                if (!tree_reg)
                begin
                    out_stat = hcb_pkg::STAT_NO_TREE;
                end
                else if (tab_vld_rd_reg)
                begin
                    out_code = tab_rd_reg[CB+LB-1:LB];
                    out_len  = tab_len;
                    if (tab_len > LB'(CB))
                    begin
                        out_stat = hcb_pkg::STAT_LONG;
                    end
                end
            end
            hcb_pkg::ST_LEAF:
            begin
                if (idx_reg < NB'(AL))
                begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg && cnt_vld_rd_reg && (cnt_rd_reg != '0))
                begin
                    w_we        = 1'b1;
                    ls_we       = 1'b1;
                    leaves_next = leaves_reg + 1'b1;
                end
                if ((idx_reg == NB'(AL)) && !pend_reg)
                begin
                    total_next = leaves_reg;
                    live_next  = leaves_reg;
                    tree_next  = (leaves_reg != '0);
                    idx_next   = '0;
                    if (leaves_reg == '0)
                    begin
                        out_load   = 1'b1;
                        out_stat   = hcb_pkg::STAT_NO_TREE;
                        state_next = hcb_pkg::ST_IDLE;
                    end
                    else if (leaves_reg == NB'(1))
                    begin
                        state_next = hcb_pkg::ST_ASSIGN;
                    end
                    else
                    begin
                        pick_clr   = 1'b1;
                        state_next = hcb_pkg::ST_SCAN;
                    end
                end
            end
            hcb_pkg::ST_SCAN:
            begin
                if (idx_reg < total_reg)
                begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                pick_en = pend_reg;
                if ((idx_reg == total_reg) && !pend_reg)
                begin
                    state_next = hcb_pkg::ST_MRG_A;
                end
            end
            hcb_pkg::ST_MRG_A:
            begin
                w_we       = 1'b1;
                w_waddr    = pick.i1;
                w_wdata    = {1'b0, pick.w1};
                state_next = hcb_pkg::ST_MRG_B;
            end
            hcb_pkg::ST_MRG_B:
            begin
                w_we       = 1'b1;
                w_waddr    = pick.i2;
                w_wdata    = {1'b0, pick.w2};
                state_next = hcb_pkg::ST_MRG_N;
            end
            hcb_pkg::ST_MRG_N:
            begin
                w_we       = 1'b1;
                w_waddr    = total_reg;
                w_wdata    = {1'b1, pick.w1 + pick.w2};
                ch_we      = 1'b1;
                total_next = total_reg + 1'b1;
                live_next  = live_reg - 1'b1;
                idx_next   = '0;
                if (live_reg == NB'(2))
                begin
                    state_next = hcb_pkg::ST_ROOT;
                end
                else
                begin
                    pick_clr   = 1'b1;
                    state_next = hcb_pkg::ST_SCAN;
                end
            end
            hcb_pkg::ST_ROOT:
            begin
                wk_we      = 1'b1;
                idx_next   = total_reg - 1'b1;
                state_next = hcb_pkg::ST_WALK_RD;
            end
            hcb_pkg::ST_WALK_RD:
            begin
                state_next = hcb_pkg::ST_WALK_L;
            end
            hcb_pkg::ST_WALK_L:
            begin
                wk_we      = 1'b1;
                wk_waddr   = ch_rd_reg[2*NB-1:NB];
                wk_wdata   = {wk_code << 1, wk_len + 1'b1};
                state_next = hcb_pkg::ST_WALK_R;
            end
            hcb_pkg::ST_WALK_R:
            begin
                wk_we    = 1'b1;
                wk_waddr = ch_rd_reg[NB-1:0];
                wk_wdata = {(wk_code << 1) | CB'(1), wk_len + 1'b1};
                if (idx_reg == leaves_reg)
                begin
                    idx_next   = '0;
                    state_next = hcb_pkg::ST_ASSIGN;
                end
                else
                begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = hcb_pkg::ST_WALK_RD;
                end
            end
            hcb_pkg::ST_ASSIGN:
            begin
                if (idx_reg < leaves_reg)
                begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    tab_we = 1'b1;
                    // lone symbol: length one, code zero
                    if (leaves_reg == NB'(1))
                    begin
                        tab_wdata = {{CB{1'b0}}, LB'(1)};
                    end
                end
                if ((idx_reg == leaves_reg) && !pend_reg)
                begin
                    out_load   = 1'b1;
                    state_next = hcb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hcb_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign code_bits   = out_code_reg;
    assign code_length = out_len_reg;
    assign status      = out_stat_reg;

endmodule
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps
module testbench;

    localparam logic [1:0] REQ_SPARE = 2'd3;

    typedef struct {
        bit          drain;
        logic [1:0]  req;
        logic [7:0]  sym;
        logic [31:0] cnt;
    } item_t;

    typedef struct {
        logic [63:0] code;
        logic [7:0]  len;
        logic [1:0]  stat;
    } code_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = hcb_pkg::REQ_WRITE;
    logic [7:0]  symbol = 8'd0;
    logic [31:0] count = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] code_bits;
    logic [7:0]  code_length;
    logic [1:0]  status;

    item_t        pending_items[$];
    code_result_t expected_codes[$];
    int           errors = 0;
    int           sent = 0;
    int           n_writes = 0;
    int           n_builds = 0;
    int           n_queries = 0;
    int           deepest = 0;
    bit           quiet;

    // predictor state
    bit [31:0]       freq[hcb_pkg::ALPHABET];
    longint unsigned wt[hcb_pkg::NODE_MAX];
    bit              act[hcb_pkg::NODE_MAX];
    int              lch[hcb_pkg::NODE_MAX];
    int              rch[hcb_pkg::NODE_MAX];
    int              leaf_sym[hcb_pkg::NODE_MAX];
    bit [63:0]       walk_code[hcb_pkg::NODE_MAX];
    int              walk_len[hcb_pkg::NODE_MAX];
    bit [63:0]       codes[hcb_pkg::ALPHABET];
    int              lens[hcb_pkg::ALPHABET];
    bit              ready;

    // generator view of nonzero counts
    bit              live[hcb_pkg::ALPHABET];

    huffman_code_builder_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .symbol(symbol), .count(count),
        .out_valid(out_valid), .out_stall(out_stall),
        .code_bits(code_bits), .code_length(code_length), .status(status)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int lightest_node(int limit);
        int best;
        bit found;
        best = 0;
        found = 1'b0;
        for (int i = 0; i < limit; i++)
        begin
            if (act[i] && (!found || wt[i] < wt[best]))
            begin
                best = i;
                found = 1'b1;
            end
        end
        return best;
    endfunction

    function automatic void build_codes();
        int leaves;
        int total;
        int a;
        int b;
        leaves = 0;
        for (int i = 0; i < hcb_pkg::NODE_MAX; i++)
            act[i] = 1'b0;
        for (int i = 0; i < hcb_pkg::ALPHABET; i++)
        begin
            codes[i] = '0;
            lens[i] = 0;
            if (freq[i] != 0)
            begin
                wt[leaves] = 64'(freq[i]);
                act[leaves] = 1'b1;
                leaf_sym[leaves] = i;
                leaves++;
            end
        end
        ready = (leaves > 0);
        if (leaves == 1)
            lens[leaf_sym[0]] = 1;
        if (leaves < 2)
            return;
        total = leaves;
        for (int live_n = leaves; live_n > 1 && total < hcb_pkg::NODE_MAX; live_n--)
        begin
            a = lightest_node(total);
            act[a] = 1'b0;
            b = lightest_node(total);
            act[b] = 1'b0;
            wt[total] = wt[a] + wt[b];
            lch[total] = a;
            rch[total] = b;
            act[total] = 1'b1;
            total++;
        end
        walk_code[total-1] = '0;
        walk_len[total-1] = 0;
        for (int i = total - 1; i >= leaves; i--)
        begin
            walk_code[lch[i]] = walk_code[i] << 1;
            walk_len[lch[i]] = walk_len[i] + 1;
            walk_code[rch[i]] = (walk_code[i] << 1) | 64'd1;
            walk_len[rch[i]] = walk_len[i] + 1;
        end
        for (int i = 0; i < leaves; i++)
        begin
            codes[leaf_sym[i]] = walk_code[i];
            lens[leaf_sym[i]] = walk_len[i];
        end
    endfunction

    function automatic code_result_t predict_code(item_t it);
        code_result_t r;
        r.code = '0;
        r.len = '0;
        r.stat = hcb_pkg::STAT_OK;
        case (it.req)
            hcb_pkg::REQ_WRITE:
            begin
                freq[it.sym] = it.cnt;
                n_writes++;
            end
            hcb_pkg::REQ_BUILD:
            begin
                build_codes();
                n_builds++;
                if (!ready)
                    r.stat = hcb_pkg::STAT_NO_TREE;
            end
            hcb_pkg::REQ_QUERY:
            begin
                n_queries++;
                if (!ready)
                    r.stat = hcb_pkg::STAT_NO_TREE;
                else
                begin
                    r.code = codes[it.sym];
                    r.len = lens[it.sym][7:0];
                    if (lens[it.sym] > hcb_pkg::CODE_BITS)
                        r.stat = hcb_pkg::STAT_LONG;
                    if (lens[it.sym] > deepest)
                        deepest = lens[it.sym];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    assign quiet = (sent >= 400 && sent < 700);

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                item_t cur;
                cur.drain = 1'b0;
                cur.req = req_type;
                cur.sym = symbol;
                cur.cnt = count;
                expected_codes.insert(expected_codes.size(), predict_code(cur));
                sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() > 0 && pending_items[0].drain)
                begin
                    in_valid <= 1'b0;
                    if (expected_codes.size() == 0 && !in_valid)
                        void'(pending_items.pop_front());
                end
                else if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 28))
                begin
                    in_valid <= 1'b1;
                    req_type <= pending_items[0].req;
                    symbol <= pending_items[0].sym;
                    count <= pending_items[0].cnt;
                    void'(pending_items.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_codes.size() == 0)
                report_mismatch("unexpected item", code_bits, 64'd0);
            else
            begin
                code_result_t w;
                w = expected_codes.pop_front();
                if (code_bits !== w.code)
                    report_mismatch("code_bits", code_bits, w.code);
                if (code_length !== w.len)
                    report_mismatch("code_length", 64'(code_length), 64'(w.len));
                if (status !== w.stat)
                    report_mismatch("status", 64'(status), 64'(w.stat));
            end
        end
        out_stall <= !quiet && ($urandom_range(99) < 28);
    end

    task automatic add_item(logic [1:0] req, logic [7:0] sym, logic [31:0] cnt);
        item_t it;
        it.drain = 1'b0;
        it.req = req;
        it.sym = sym;
        it.cnt = cnt;
        pending_items.insert(pending_items.size(), it);
        if (req == hcb_pkg::REQ_WRITE)
            live[sym] = (cnt != 0);
    endtask

    task automatic add_drain();
        item_t it;
        it.drain = 1'b1;
        it.req = hcb_pkg::REQ_WRITE;
        it.sym = 8'd0;
        it.cnt = 32'd0;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic clear_counts();
        for (int s = 0; s < hcb_pkg::ALPHABET; s++)
            if (live[s])
                add_item(hcb_pkg::REQ_WRITE, s[7:0], 32'd0);
    endtask

    initial
    begin
        int phase;
        int k;
        int qn;
        bit [31:0] fa;
        bit [31:0] fb;
        bit [31:0] fc;

        for (int s = 0; s < hcb_pkg::ALPHABET; s++)
        begin
            freq[s] = '0;
            codes[s] = '0;
            lens[s] = 0;
            live[s] = 1'b0;
        end
        ready = 1'b0;

        // directed
        add_item(hcb_pkg::REQ_QUERY, 8'd0, 32'd0);
        add_item(hcb_pkg::REQ_BUILD, 8'd0, 32'd0);
        add_item(hcb_pkg::REQ_QUERY, 8'd255, 32'd0);
        add_item(hcb_pkg::REQ_WRITE, 8'd0, 32'hFFFF_FFFF);
        add_item(hcb_pkg::REQ_BUILD, 8'd37, 32'd0);
        add_item(hcb_pkg::REQ_QUERY, 8'd0, 32'd0);
        add_item(hcb_pkg::REQ_QUERY, 8'd255, 32'd0);
        add_item(hcb_pkg::REQ_WRITE, 8'd255, 32'd1);
        add_item(hcb_pkg::REQ_QUERY, 8'd255, 32'd0);
        add_item(REQ_SPARE, 8'hFF, 32'hFFFF_FFFF);
        add_item(hcb_pkg::REQ_BUILD, 8'd0, 32'd0);
        add_item(hcb_pkg::REQ_QUERY, 8'd0, 32'd0);
        add_item(hcb_pkg::REQ_QUERY, 8'd255, 32'd0);
        add_item(hcb_pkg::REQ_WRITE, 8'd128, 32'd1);
        add_item(hcb_pkg::REQ_WRITE, 8'd127, 32'd1);
        add_item(hcb_pkg::REQ_BUILD, 8'd0, 32'd0);
        add_item(hcb_pkg::REQ_QUERY, 8'd127, 32'd0);
        add_item(hcb_pkg::REQ_QUERY, 8'd128, 32'd0);
        add_item(hcb_pkg::REQ_QUERY, 8'd0, 32'd0);
        add_item(hcb_pkg::REQ_WRITE, 8'd0, 32'd0);
        add_item(hcb_pkg::REQ_QUERY, 8'd0, 32'd0);
        add_drain();

        // random phases
        phase = 0;
        while (pending_items.size() + 21 < 1350)
        begin
            phase++;
            if (phase == 40 || phase == 110 || phase == 25)
            begin
                clear_counts();
                if (phase == 25)
                begin
                    // fibonacci counts give the deepest tree
                    fa = 32'd1;
                    fb = 32'd1;
                    for (int i = 0; i < 47; i++)
                    begin
                        add_item(hcb_pkg::REQ_WRITE, i[7:0] * 8'd5, fa);
                        fc = fa + fb;
                        fa = fb;
                        fb = fc;
                    end
                end
                else
                    for (int s = 0; s < hcb_pkg::ALPHABET; s++)
                        add_item(hcb_pkg::REQ_WRITE, s[7:0],
                                 phase == 40 ? $urandom_range(1, 3) : $urandom);
                add_item(hcb_pkg::REQ_BUILD, 8'($urandom), $urandom);
                for (int i = 0; i < 30; i++)
                    add_item(hcb_pkg::REQ_QUERY, 8'($urandom), $urandom);
                if (phase == 40)
                    add_drain();
            end
            else if ($urandom_range(99) < 80)
            begin
                clear_counts();
                k = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 12);
                for (int i = 0; i < k; i++)
                    add_item(hcb_pkg::REQ_WRITE, 8'($urandom),
                             $urandom_range(1) ? $urandom_range(1, 4) : $urandom | 32'd1);
                add_item(hcb_pkg::REQ_BUILD, 8'($urandom), $urandom);
                qn = $urandom_range(3, 12);
                for (int i = 0; i < qn; i++)
                    add_item(hcb_pkg::REQ_QUERY, 8'($urandom), $urandom);
                if ($urandom_range(3) == 0)
                    add_item(hcb_pkg::REQ_WRITE, 8'($urandom), $urandom);
            end
            else
                for (int i = 0; i < 8; i++)
                    add_item(2'($urandom_range(3)), 8'($urandom),
                             $urandom_range(1) ? $urandom : 32'd0);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_valid || expected_codes.size() != 0)
            @(negedge clk);
        repeat (50) @(posedge clk);

        $display("covered %0d writes, %0d builds, %0d queries; deepest code %0d bits",
                 n_writes, n_builds, n_queries, deepest);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout");
        $display("TEST FAILED");
        $finish;
    end

endmodule
